// ===== rtl/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// MIME transfer decoder package
// Shared types, character codes and symbol tables of the decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int ByteWidth = 8;
    localparam int AccWidth  = 12;
    localparam int BitsWidth = 4;

    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,
        MODE_BASE64 = 2'd1,
        MODE_QP     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        QP_IDLE = 2'd0,
        QP_EQ   = 2'd1,
        QP_HELD = 2'd2
    } qp_phase_t;

    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [1:0]           qp_phase;
        logic [ByteWidth-1:0] held_byte;
        logic [AccWidth-1:0]  bit_accumulator;
        logic [BitsWidth-1:0] bits_held;
        logic                 pad_seen;
    } stream_state_t;

    typedef struct packed {
        logic [ByteWidth-1:0] out_byte;
        logic                 byte_valid;
        logic                 run_last;
        logic                 stream_end;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } decode_t;

    // Returns {valid, value} for a base64 alphabet symbol.
    function automatic logic [6:0] b64_lookup(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = 4'(c - 8'h61 + 8'd10);
        end
        return r;
    endfunction

endpackage

// ===== rtl/mtd_decode.sv =====
// ----------------------------------------------------------------------------
// MIME transfer decoder: decode stage
// Holds the per-stream state and turns one registered input word into up
// to two result words in a single pass.
// ----------------------------------------------------------------------------
module mtd_decode
    import mtd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] decode_mode,
    input  logic       clear,
    input  logic       advance,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output decode_t    dec
);

    stream_state_t st_reg;
    stream_state_t st_next;

    logic [6:0]           b64;
    logic [AccWidth-1:0]  acc_new;
    logic [BitsWidth-1:0] bits_sum;
    logic [AccWidth-1:0]  acc_shifted;
    logic [1:0]           n;
    logic [7:0]           byte0;
    logic [7:0]           byte1;

    always_comb begin
        b64         = b64_lookup(in_byte);
        acc_new     = {st_reg.bit_accumulator[AccWidth-7:0], b64[5:0]};
        bits_sum    = st_reg.bits_held + BitsWidth'(6);
        acc_shifted = '0;
        st_next     = st_reg;
        n           = 2'd0;
        byte0       = '0;
        byte1       = '0;

        unique case (decode_mode)
            MODE_BASE64: begin
                if (!st_reg.pad_seen) begin
                    if (in_byte == CHAR_EQ) begin
                        st_next.pad_seen = 1'b1;
                    end else if (b64[6]) begin
                        st_next.bit_accumulator = acc_new;
                        if (bits_sum >= BitsWidth'(8)) begin
                            st_next.bits_held = bits_sum - BitsWidth'(8);
                            acc_shifted       = acc_new >> st_next.bits_held;
                            byte0             = acc_shifted[7:0];
                            n                 = 2'd1;
                        end else begin
                            st_next.bits_held = bits_sum;
                        end
                    end
                end
            end
            MODE_QP: begin
                unique case (st_reg.qp_phase)
                    QP_IDLE: begin
                        if (in_byte == CHAR_EQ && !in_last) begin
                            st_next.qp_phase = QP_EQ;
                        end else begin
                            byte0 = in_byte;
                            n     = 2'd1;
                        end
                    end
                    QP_EQ: begin
                        if (in_last) begin
                            byte0            = CHAR_EQ;
                            byte1            = in_byte;
                            n                = 2'd2;
                            st_next.qp_phase = QP_IDLE;
                        end else begin
                            st_next.held_byte = in_byte;
                            st_next.qp_phase  = QP_HELD;
                        end
                    end
                    default: begin
                        if (!(st_reg.held_byte == CHAR_CR && in_byte == CHAR_LF)) begin
                            byte0 = {hex_value(st_reg.held_byte), hex_value(in_byte)};
                            n     = 2'd1;
                        end
                        st_next.qp_phase = QP_IDLE;
                    end
                endcase
            end
            default: begin
                byte0 = in_byte;
                n     = 2'd1;
            end
        endcase

        if (in_last) begin
            st_next = '0;
        end

        dec.r0.out_byte   = byte0;
        dec.r0.byte_valid = (n != 2'd0);
        dec.r0.run_last   = (n != 2'd2);
        dec.r0.stream_end = (n != 2'd2) && in_last;
        dec.r1.out_byte   = byte1;
        dec.r1.byte_valid = 1'b1;
        dec.r1.run_last   = 1'b1;
        dec.r1.stream_end = in_last;
        dec.count         = (n == 2'd0 && in_last) ? 2'd1 : n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== rtl/mtd_out_buf.sv =====
// ----------------------------------------------------------------------------
// MIME transfer decoder: result register
// Two-slot result register that presents the result words of one input
// in order and takes the next set as the last one leaves.
// ----------------------------------------------------------------------------
module mtd_out_buf
    import mtd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  decode_t dec,
    output logic    load_ok,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    res0_reg;
    result_t    res0_next;
    result_t    res1_reg;
    result_t    res1_next;
    logic       pop;

    always_comb begin
        pop       = (cnt_reg != 2'd0) && m_ready;
        load_ok   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
        cnt_next  = cnt_reg;
        res0_next = res0_reg;
        res1_next = res1_reg;
        if (load) begin
            cnt_next  = dec.count;
            res0_next = dec.r0;
            res1_next = dec.r1;
        end else if (pop) begin
            cnt_next  = cnt_reg - 2'd1;
            res0_next = res1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign res     = res0_reg;

endmodule

// ===== rtl/mime_transfer_decoder.sv =====
// ----------------------------------------------------------------------------
// MIME transfer decoder
// Decodes a base64, quoted-printable or pass-through byte stream.
// ----------------------------------------------------------------------------
// The decoder takes one input word per cycle while the result register can
// take its results. An accepted input word is held in the input register,
// and its result words are then held in the result register. Most input
// words give at most one result word, so the sustained rate is one word per
// cycle while the consumer keeps m_ready high. A quoted-printable stream
// ending in '=' and one more byte gives two result words from that last
// input; the input side then stalls while the result register drains them.
// The user must write the mode register via the cfg port only while the
// decoder is idle; the block does not check it. A write clears stream state.
module mime_transfer_decoder
    import mtd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_stream_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_run_last,
    output logic       m_stream_end
);

    logic [1:0] decode_mode_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       cfg_write;
    logic       advance;
    logic       load_ok;
    decode_t    dec;
    result_t    res;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign advance = in_valid_reg && ((dec.count == 2'd0) || load_ok);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            decode_mode_reg <= MODE_PASS;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_write) begin
                decode_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_stream_last;
        end
    end

    mtd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .decode_mode (decode_mode_reg),
        .clear       (cfg_write),
        .advance     (advance),
        .in_byte     (in_byte_reg),
        .in_last     (in_last_reg),
        .dec         (dec)
    );

    mtd_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && (dec.count != 2'd0)),
        .dec     (dec),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res     (res)
    );

    assign m_out_byte   = res.out_byte;
    assign m_byte_valid = res.byte_valid;
    assign m_run_last   = res.run_last;
    assign m_stream_end = res.stream_end;

endmodule

// ===== rtl/mtd_checker.sv =====
// ----------------------------------------------------------------------------
// MIME transfer decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mtd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_run_last,
    input logic       m_stream_end
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_byte_valid) && $stable(m_run_last) && $stable(m_stream_end))
        else $error("result word changed while stalled");

    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_run_last && m_stream_end && (m_out_byte == 8'd0))
        else $error("end marker without end flags or with data");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> m_run_last)
        else $error("stream end on a word that is not the last of its run");

    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid && m_byte_valid && m_run_last)
        else $error("first of two words not followed by its partner");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind mime_transfer_decoder mtd_checker u_mtd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_byte_valid (m_byte_valid),
    .m_run_last   (m_run_last),
    .m_stream_end (m_stream_end)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIME transfer decoder testbench
// Drives encoded byte streams in every decode mode through the valid/ready
// channels, with random gaps on both sides. Each accepted word is checked
// against a local decode model or script row, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import mtd_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS = 1300;
    localparam int SCRIPT_ROWS = 25;

    typedef struct {
        bit         set_mode;
        logic [1:0] mode;
        logic [7:0] data;
        logic       last;
        bit         typed;
        int         count;
        result_t    r0;
        result_t    r1;
    } script_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'd0;
    logic       s_stream_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_run_last;
    logic       m_stream_end;

    logic [1:0]  cur_mode = MODE_PASS;
    qp_phase_t   qp_state = QP_IDLE;
    logic [7:0]  qp_held = 8'd0;
    logic [11:0] b64_bits = 12'd0;
    logic [3:0]  b64_count = 4'd0;
    bit          b64_closed = 1'b0;

    result_t    pending_decoded[$];
    logic [7:0] stream_buf[$];
    bit         quiet = 1'b0;
    bit         paused_once = 1'b0;
    int         words_sent = 0;
    int         results_seen = 0;
    int         streams_sent = 0;
    int         mode_writes = 0;
    int         failures = 0;

    logic [1:0] mode_order [4] = '{MODE_PASS, MODE_BASE64, MODE_QP, MODE_SPARE};

    script_row_t script [SCRIPT_ROWS] = '{
        '{1'b0, MODE_PASS,   8'h00,   1'b0, 1'b1, 1, {8'h00, 1'b1, 1'b1, 1'b0}, '0},
        '{1'b0, MODE_PASS,   8'hFF,   1'b1, 1'b1, 1, {8'hFF, 1'b1, 1'b1, 1'b1}, '0},
        '{1'b1, MODE_SPARE,  8'hA5,   1'b1, 1'b1, 1, {8'hA5, 1'b1, 1'b1, 1'b1}, '0},
        '{1'b1, MODE_BASE64, "T",     1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_BASE64, "W",     1'b0, 1'b0, 0, '0, '0},
        '{1'b0, MODE_BASE64, "*",     1'b0, 1'b0, 0, '0, '0},
        '{1'b0, MODE_BASE64, "F",     1'b0, 1'b0, 0, '0, '0},
        '{1'b0, MODE_BASE64, "u",     1'b0, 1'b0, 0, '0, '0},
        '{1'b0, MODE_BASE64, "+",     1'b0, 1'b0, 0, '0, '0},
        '{1'b0, MODE_BASE64, "/",     1'b0, 1'b0, 0, '0, '0},
        '{1'b0, MODE_BASE64, CHAR_EQ, 1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_BASE64, "A",     1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_BASE64, "B",     1'b1, 1'b1, 1, {8'h00, 1'b0, 1'b1, 1'b1}, '0},
        '{1'b1, MODE_QP,     CHAR_EQ, 1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     "a",     1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     "F",     1'b0, 1'b0, 0, '0, '0},
        '{1'b0, MODE_QP,     CHAR_EQ, 1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     CHAR_CR, 1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     CHAR_LF, 1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     CHAR_EQ, 1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     "G",     1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     "z",     1'b0, 1'b1, 1, {8'h00, 1'b1, 1'b1, 1'b0}, '0},
        '{1'b0, MODE_QP,     CHAR_EQ, 1'b0, 1'b1, 0, '0, '0},
        '{1'b0, MODE_QP,     "x",     1'b1, 1'b1, 2, {CHAR_EQ, 1'b1, 1'b0, 1'b0},
                                                     {8'h78, 1'b1, 1'b1, 1'b1}},
        '{1'b0, MODE_QP,     CHAR_EQ, 1'b1, 1'b1, 1, {CHAR_EQ, 1'b1, 1'b1, 1'b1}, '0}
    };

    mime_transfer_decoder u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_stream_last (s_stream_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_run_last    (m_run_last),
        .m_stream_end  (m_stream_end)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 16);
    end

    function automatic void clear_decoder_state();
        qp_state = QP_IDLE;
        qp_held = 8'd0;
        b64_bits = 12'd0;
        b64_count = 4'd0;
        b64_closed = 1'b0;
    endfunction

    function automatic void expect_result(input result_t r);
        pending_decoded.insert(pending_decoded.size(), r);
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        stream_buf.insert(stream_buf.size(), b);
    endfunction

    function automatic bit b64_sym_value(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        if (c >= "A" && c <= "Z") begin
            v = 6'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            v = 6'(c - "a" + 26);
        end else if (c >= "0" && c <= "9") begin
            v = 6'(c - "0" + 52);
        end else if (c == "+") begin
            v = 6'd62;
        end else if (c == "/") begin
            v = 6'd63;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - "0");
        end
        if (c >= "A" && c <= "F") begin
            return 4'(c - "A" + 10);
        end
        if (c >= "a" && c <= "f") begin
            return 4'(c - "a" + 10);
        end
        return 4'd0;
    endfunction

    function automatic int mime_decode(input logic [7:0] data, input logic last,
                                       output result_t r0, output result_t r1);
        logic [7:0] bytes [2];
        logic [5:0] sym;
        int n;
        n = 0;
        bytes[0] = 8'd0;
        bytes[1] = 8'd0;
        case (cur_mode)
            MODE_BASE64: begin
                if (!b64_closed) begin
                    if (data == CHAR_EQ) begin
                        b64_closed = 1'b1;
                    end else if (b64_sym_value(data, sym)) begin
                        b64_bits = {b64_bits[5:0], sym};
                        b64_count = b64_count + 4'd6;
                        if (b64_count >= 4'd8) begin
                            b64_count = b64_count - 4'd8;
                            bytes[0] = 8'(b64_bits >> b64_count);
                            n = 1;
                        end
                    end
                end
            end
            MODE_QP: begin
                case (qp_state)
                    QP_IDLE: begin
                        if (data == CHAR_EQ && !last) begin
                            qp_state = QP_EQ;
                        end else begin
                            bytes[0] = data;
                            n = 1;
                        end
                    end
                    QP_EQ: begin
                        if (last) begin
                            bytes[0] = CHAR_EQ;
                            bytes[1] = data;
                            n = 2;
                            qp_state = QP_IDLE;
                        end else begin
                            qp_held = data;
                            qp_state = QP_HELD;
                        end
                    end
                    default: begin
                        if (!(qp_held == CHAR_CR && data == CHAR_LF)) begin
                            bytes[0] = {hex_nibble(qp_held), hex_nibble(data)};
                            n = 1;
                        end
                        qp_state = QP_IDLE;
                    end
                endcase
            end
            default: begin
                bytes[0] = data;
                n = 1;
            end
        endcase

        r0 = '0;
        r1 = '0;
        if (n == 0) begin
            if (last) begin
                r0.run_last = 1'b1;
                r0.stream_end = 1'b1;
                n = 1;
            end
        end else begin
            r0.out_byte = bytes[0];
            r0.byte_valid = 1'b1;
            r0.run_last = (n == 1);
            r0.stream_end = (n == 1) && last;
            r1.out_byte = bytes[1];
            r1.byte_valid = 1'b1;
            r1.run_last = 1'b1;
            r1.stream_end = last;
        end
        if (last) begin
            clear_decoder_state();
        end
        return n;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(negedge aclk) begin : result_monitor
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_decoded.size() == 0) begin
                $error("result word 0x%0h arrived with nothing outstanding", m_out_byte);
                failures++;
            end else begin
                want = pending_decoded.pop_front();
                check_field("out_byte", want.out_byte, m_out_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(m_byte_valid));
                check_field("run_last", 8'(want.run_last), 8'(m_run_last));
                check_field("stream_end", 8'(want.stream_end), 8'(m_stream_end));
                results_seen++;
            end
        end
    end

    task automatic push_word(input logic [7:0] data, input logic last);
        while (!quiet && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= data;
        s_stream_last <= last;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        words_sent++;
        quiet = (words_sent >= 400) && (words_sent < 650);
    endtask

    task automatic feed(input logic [7:0] data, input logic last);
        result_t r0, r1;
        int n;
        n = mime_decode(data, last, r0, r1);
        if (n > 0) begin
            expect_result(r0);
        end
        if (n > 1) begin
            expect_result(r1);
        end
        push_word(data, last);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_decoded.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_mode = mode;
        clear_decoder_state();
        mode_writes++;
    endtask

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 26) begin
            return 8'("A" + v);
        end
        if (v < 52) begin
            return 8'("a" + v - 26);
        end
        if (v < 62) begin
            return 8'("0" + v - 52);
        end
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 10) begin
            return 8'("0" + v);
        end
        return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    task automatic push_symbol(input logic [7:0] sym);
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: append_byte(CHAR_CR);
                1: append_byte(CHAR_LF);
                default: append_byte(8'($urandom));
            endcase
        end
        append_byte(sym);
    endtask

    task automatic build_plain();
        stream_buf.delete();
        repeat ($urandom_range(16, 1)) append_byte(8'($urandom));
    endtask

    task automatic build_base64();
        logic [23:0] group;
        int remaining, take;
        bit pad;
        stream_buf.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(16, 1)) append_byte(8'($urandom));
            return;
        end
        remaining = $urandom_range(12, 1);
        pad = ($urandom_range(3) != 0);
        while (remaining > 0) begin
            take = (remaining > 3) ? 3 : remaining;
            remaining -= take;
            group = {8'($urandom), 8'($urandom), 8'($urandom)};
            for (int k = 0; k < 4; k++) begin
                if (k <= take) begin
                    push_symbol(b64_char(group[23 - 6 * k -: 6]));
                end else if (pad) begin
                    push_symbol(CHAR_EQ);
                end
            end
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(3, 1)) append_byte(b64_char(6'($urandom)));
        end
    endtask

    task automatic build_qp();
        logic [7:0] v;
        int pick;
        stream_buf.delete();
        if ($urandom_range(6) == 0) begin
            repeat ($urandom_range(16, 1)) begin
                append_byte(($urandom_range(3) == 0) ? CHAR_EQ : 8'($urandom));
            end
            return;
        end
        repeat ($urandom_range(10, 1)) begin
            v = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 40) begin
                append_byte((v == CHAR_EQ) ? 8'("Q") : v);
            end else if (pick < 70) begin
                append_byte(CHAR_EQ);
                append_byte(hex_char(v[7:4], 1'($urandom_range(1))));
                append_byte(hex_char(v[3:0], 1'($urandom_range(1))));
            end else if (pick < 82) begin
                append_byte(CHAR_EQ);
                append_byte(CHAR_CR);
                append_byte(CHAR_LF);
            end else if (pick < 92) begin
                append_byte(CHAR_EQ);
                append_byte(v);
                append_byte(8'($urandom));
            end else begin
                append_byte(CHAR_EQ);
                append_byte(CHAR_CR);
                append_byte(v);
            end
        end
        pick = $urandom_range(5);
        if (pick <= 1) begin
            append_byte(CHAR_EQ);
        end
        if (pick == 1) begin
            append_byte(8'($urandom));
        end
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_buf.size(); i++) begin
            if (!paused_once && words_sent >= 700 && i > 0) begin
                drain_results();
                paused_once = 1'b1;
            end
            feed(stream_buf[i], i == stream_buf.size() - 1);
        end
        streams_sent++;
    endtask

    initial begin : stimulus
        result_t p0, p1;
        int n;
        int phase;
        int pick;
        int random_target;
        logic [1:0] next_mode;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            if (script[i].set_mode) begin
                drain_results();
                write_mode(script[i].mode);
            end
            n = mime_decode(script[i].data, script[i].last, p0, p1);
            if (script[i].typed) begin
                n = script[i].count;
                p0 = script[i].r0;
                p1 = script[i].r1;
            end
            if (n > 0) begin
                expect_result(p0);
            end
            if (n > 1) begin
                expect_result(p1);
            end
            push_word(script[i].data, script[i].last);
        end
        streams_sent += 5;

        random_target = words_sent + RANDOM_WORDS;
        phase = 0;
        while (words_sent < random_target) begin
            if (phase < 4) begin
                next_mode = mode_order[phase];
            end else begin
                pick = $urandom_range(9);
                if (pick < 4) begin
                    next_mode = MODE_BASE64;
                end else if (pick < 8) begin
                    next_mode = MODE_QP;
                end else if (pick == 8) begin
                    next_mode = MODE_PASS;
                end else begin
                    next_mode = MODE_SPARE;
                end
            end
            phase++;
            drain_results();
            write_mode(next_mode);
            repeat ($urandom_range(6, 2)) begin
                case (next_mode)
                    MODE_BASE64: build_base64();
                    MODE_QP: build_qp();
                    default: build_plain();
                endcase
                send_stream();
            end
        end

        drain_results();
        $display("Sent %0d input words in %0d streams with %0d mode writes over all four codes.",
                 words_sent, streams_sent, mode_writes);
        $display("Checked %0d result words, end markers, short escapes and soft breaks included.",
                 results_seen);
        if (failures == 0) begin
            $display("mime_transfer_decoder verification clean");
        end else begin
            $display("mime_transfer_decoder verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("mime_transfer_decoder verification failed");
        $finish;
    end

endmodule
